// ===== design/cvbc_pkg.sv =====
package cvbc_pkg;

  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned NUM_W   = TEMP_W + POS_W;
  localparam int unsigned CNT_W   = 4;

  localparam logic [POS_W-1:0] POS_SCALE = 10'd1000;
  localparam logic [POS_W-1:0] POS_FULL  = 10'd1000;
  localparam logic [POS_W-1:0] POS_ZERO  = 10'd0;
  localparam logic [CNT_W-1:0] DIV_STEPS = 4'd10;

  localparam logic REG_BAND_LOW  = 1'b0;
  localparam logic REG_BAND_HIGH = 1'b1;

  localparam logic signed [TEMP_W-1:0] BAND_LOW_RST  = 16'sd0;
  localparam logic signed [TEMP_W-1:0] BAND_HIGH_RST = 16'sd1000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE,
    ST_WRITE
  } cvbc_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } cvbc_div_stat_t;

endpackage

// ===== design/cvbc_div.sv =====
module cvbc_div
  import cvbc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [TEMP_W-1:0]     diff_i,
  input  logic [TEMP_W-1:0]     den_i,
  output cvbc_div_stat_t        stat_o,
  output logic [POS_W-1:0]      quo_o
);

  logic [NUM_W-1:0]  num;
  logic [TEMP_W-1:0] rem_q, rem_d;
  logic [POS_W-1:0]  low_q, low_d;
  logic [POS_W-1:0]  quo_q, quo_d;
  logic [TEMP_W-1:0] den_q, den_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [TEMP_W:0]   trial;
  logic              fits;

  // scale by 1000, registered into the remainder and shift-in bits
  assign num   = NUM_W'(diff_i) * NUM_W'(POS_SCALE);
  assign trial = {rem_q, low_q[POS_W-1]} - {1'b0, den_q};
  assign fits  = !trial[TEMP_W];

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = num[NUM_W-1:POS_W];
      low_d  = num[POS_W-1:0];
      den_d  = den_i;
      cnt_d  = DIV_STEPS;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one restoring step per cycle
      rem_d = fits ? trial[TEMP_W-1:0] : {rem_q[TEMP_W-2:0], low_q[POS_W-1]};
      low_d = {low_q[POS_W-2:0], 1'b0};
      quo_d = {quo_q[POS_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

// ===== design/cooling_valve_band_controller.sv =====
// channel  | handshake                    | payload
// in       | in_valid_i / in_stall_o      | temperature_i, start_request_i,
//          |                              | manual_open_active_i, manual_close_active_i
// out      | out_valid_o / out_stall_i    | command_issued_o, set_auto_mode_o,
//          |                              | analog_position_o, digital_open_o
// cfg      | cfg_wr_en_i                  | cfg_idx_i, cfg_data_i
//
// an enabled transaction inside a non-empty band goes through accept, scale, 10 restoring
// divider steps, divider done, write to the output register; any other skips to
// the write. reset clears the sequencer, previous enable, and loads band 0 to 1000
// the output register holds a result under out_stall_i; the next transaction
// is accepted while it waits, and the write stage waits for the register to free
module cooling_valve_band_controller
  import cvbc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_wr_en_i,
  input  logic                     cfg_idx_i,
  input  logic [TEMP_W-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [TEMP_W-1:0] temperature_i,
  input  logic                     start_request_i,
  input  logic                     manual_open_active_i,
  input  logic                     manual_close_active_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     command_issued_o,
  output logic                     set_auto_mode_o,
  output logic [POS_W-1:0]         analog_position_o,
  output logic                     digital_open_o
);

  cvbc_state_e state_q, state_d;

  logic signed [TEMP_W-1:0] band_low_q, band_high_q;
  logic                     prev_en_q;

  logic                     in_acc;
  logic                     en;
  logic                     below;
  logic                     above;
  logic                     use_div;
  logic signed [TEMP_W:0]   diff;
  logic signed [TEMP_W:0]   span;

  logic                     use_div_q;
  logic                     res_issued_q;
  logic                     res_auto_q;
  logic [POS_W-1:0]         res_pos_q;
  logic                     res_dig_q;
  logic [TEMP_W-1:0]        diff_q;
  logic [TEMP_W-1:0]        den_q;

  logic                     div_start;
  cvbc_div_stat_t           div_stat;
  logic [POS_W-1:0]         quo;
  logic [POS_W-1:0]         pos_sel;
  logic                     wr_en;

  logic                     out_valid_q;
  logic                     out_issued_q;
  logic                     out_auto_q;
  logic [POS_W-1:0]         out_pos_q;
  logic                     out_dig_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign en      = start_request_i && !manual_open_active_i && !manual_close_active_i;
  assign below   = temperature_i < band_low_q;
  assign above   = temperature_i > band_high_q;
  assign diff    = {temperature_i[TEMP_W-1], temperature_i} - {band_low_q[TEMP_W-1], band_low_q};
  assign span    = {band_high_q[TEMP_W-1], band_high_q} - {band_low_q[TEMP_W-1], band_low_q};
  assign use_div = en && !below && !above && (band_high_q > band_low_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_low_q  <= BAND_LOW_RST;
      band_high_q <= BAND_HIGH_RST;
    end else if (cfg_wr_en_i) begin
      unique case (cfg_idx_i)
        REG_BAND_LOW:  band_low_q  <= cfg_data_i;
        REG_BAND_HIGH: band_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_en_q <= 1'b0;
    end else if (in_acc) begin
      prev_en_q <= en;
    end
  end

  // transaction decode, payload only
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      use_div_q    <= use_div;
      res_issued_q <= en || prev_en_q;
      res_auto_q   <= en && !prev_en_q;
      res_pos_q    <= (en && above && !below) ? POS_FULL : POS_ZERO;
      res_dig_q    <= en && below;
      diff_q       <= diff[TEMP_W-1:0];
      den_q        <= span[TEMP_W-1:0];
    end
  end

  cvbc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .diff_i  (diff_q),
    .den_i   (den_q),
    .stat_o  (div_stat),
    .quo_o   (quo)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = use_div ? ST_LOAD : ST_WRITE;
      ST_LOAD:   state_d = ST_DIVIDE;
      ST_DIVIDE: if (div_stat.done) state_d = ST_WRITE;
      ST_WRITE:  if (wr_en) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    div_start  = (state_q == ST_LOAD);
    wr_en      = (state_q == ST_WRITE) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign pos_sel = !use_div_q ? res_pos_q : ((quo > POS_FULL) ? POS_FULL : quo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wr_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      out_issued_q <= res_issued_q;
      out_auto_q   <= res_auto_q;
      out_pos_q    <= pos_sel;
      out_dig_q    <= res_dig_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign command_issued_o  = out_issued_q;
  assign set_auto_mode_o   = out_auto_q;
  assign analog_position_o = out_pos_q;
  assign digital_open_o    = out_dig_q;

  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after transaction");

  a_done_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_DIVIDE)
    else $error("divider done outside divide state");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> analog_position_o <= POS_FULL)
    else $error("analog position above full scale");

  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !command_issued_o |->
      analog_position_o == POS_ZERO && !digital_open_o && !set_auto_mode_o)
    else $error("idle result carries a command");

endmodule

// ===== test/cooling_valve_band_controller_tb.sv =====
`timescale 1ns / 1ps

module cooling_valve_band_controller_tb;
  import cvbc_pkg::*;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic                     start;
    logic                     man_open;
    logic                     man_close;
    bit                       drain_first;
  } tick_t;

  typedef struct packed {
    logic             issued;
    logic             auto_mode;
    logic [POS_W-1:0] pos;
    logic             dig;
  } valve_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_wr_en_i = 1'b0;
  logic cfg_idx_i = REG_BAND_LOW;
  logic [TEMP_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [TEMP_W-1:0] temperature_i = '0;
  logic start_request_i = 1'b0;
  logic manual_open_active_i = 1'b0;
  logic manual_close_active_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic command_issued_o;
  logic set_auto_mode_o;
  logic [POS_W-1:0] analog_position_o;
  logic digital_open_o;

  tick_t pending_ticks[$];
  valve_cmd_t expected_cmds[$];
  tick_t cur_tick;
  logic signed [TEMP_W-1:0] band_lo = BAND_LOW_RST;
  logic signed [TEMP_W-1:0] band_hi = BAND_HIGH_RST;
  logic was_enabled = 1'b0;
  int errors = 0;
  int gap_left = 0;
  int quiet_tx = 0;
  int stall_left = 0;
  int hold_left = 0;
  int quiet_rx = 0;
  int results_seen = 0;

  cooling_valve_band_controller dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // mostly short gaps, a few long ones, and occasional runs with none
  function automatic int idle_len(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic valve_cmd_t valve_command(tick_t tk);
    valve_cmd_t c;
    logic en;
    longint num;
    longint den;
    longint q;
    c = '0;
    en = tk.start && !(tk.man_open || tk.man_close);
    if (en) begin
      c.issued = 1'b1;
      c.auto_mode = !was_enabled;
      if (tk.temp < band_lo) begin
        c.dig = 1'b1;
      end else if (tk.temp > band_hi) begin
        c.pos = POS_FULL;
      end else if (band_hi > band_lo) begin
        num = (longint'(tk.temp) - longint'(band_lo)) * 1000;
        den = longint'(band_hi) - longint'(band_lo);
        if (num > 0) begin
          q = num / den;
          if (q > 1000) q = 1000;
          c.pos = POS_W'(q);
        end
      end
    end else if (was_enabled) begin
      c.issued = 1'b1;
    end
    was_enabled = en;
    return c;
  endfunction

  // driver
  always @(posedge clk_i) begin : drive_proc
    logic next_valid;
    next_valid = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_cmds = {expected_cmds, valve_command(cur_tick)};
        next_valid = 1'b0;
        gap_left = idle_len(quiet_tx);
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ticks.size() > 0 &&
                     !(pending_ticks[0].drain_first && expected_cmds.size() > 0)) begin
          cur_tick = pending_ticks.pop_front();
          next_valid = 1'b1;
          temperature_i <= cur_tick.temp;
          start_request_i <= cur_tick.start;
          manual_open_active_i <= cur_tick.man_open;
          manual_close_active_i <= cur_tick.man_close;
        end
      end
    end
    in_valid_i <= next_valid;
  end

  // monitor
  always @(posedge clk_i) begin : check_proc
    valve_cmd_t got;
    valve_cmd_t want;
    logic next_stall;
    logic took;
    took = 1'b0;
    next_stall = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        took = 1'b1;
        results_seen++;
        got = {command_issued_o, set_auto_mode_o, analog_position_o, digital_open_o};
        if (expected_cmds.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction issued=%0d auto=%0d pos=%0d dig=%0d",
                   $time, got.issued, got.auto_mode, got.pos, got.dig);
        end else begin
          want = expected_cmds.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected issued=%0d auto=%0d pos=%0d dig=%0d",
                     $time, want.issued, want.auto_mode, want.pos, want.dig);
            $display("%0t:          actual   issued=%0d auto=%0d pos=%0d dig=%0d",
                     $time, got.issued, got.auto_mode, got.pos, got.dig);
          end
        end
        // long back-pressure so the block fills and stalls its input
        if (results_seen == 400 || results_seen == 1200) hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        next_stall = 1'b1;
      end else if (took) begin
        stall_left = idle_len(quiet_rx);
        next_stall = (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end else if (!out_valid_o && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 7);
        next_stall = 1'b1;
      end
    end
    out_stall_i <= next_stall;
  end

  task automatic tick(input int temp, input bit start, input bit mo, input bit mc,
                      input bit drain = 1'b0);
    tick_t tk;
    tk.temp = TEMP_W'(temp);
    tk.start = start;
    tk.man_open = mo;
    tk.man_close = mc;
    tk.drain_first = drain;
    pending_ticks = {pending_ticks, tk};
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_ticks.size() > 0 || in_valid_i || expected_cmds.size() > 0);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_band(input int lo, input int hi);
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b1;
    cfg_idx_i <= REG_BAND_LOW;
    cfg_data_i <= TEMP_W'(lo);
    @(posedge clk_i);
    cfg_idx_i <= REG_BAND_HIGH;
    cfg_data_i <= TEMP_W'(hi);
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    band_lo = TEMP_W'(lo);
    band_hi = TEMP_W'(hi);
    @(negedge clk_i);
  endtask

  task automatic random_phase(input int lo, input int hi, input int count, input int drain_at);
    int t;
    int r;
    write_band(lo, hi);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 3);
      if (r < 2 && band_lo <= band_hi)
        t = band_lo + int'($urandom_range(0, int'(band_hi) - int'(band_lo)));
      else if (r == 2)
        t = (($urandom_range(0, 1) == 1) ? int'(band_hi) : int'(band_lo))
            + int'($urandom_range(0, 4)) - 2;
      else
        t = int'($signed(16'($urandom)));
      tick(t, $urandom_range(0, 9) != 0, $urandom_range(0, 11) == 0,
           $urandom_range(0, 11) == 0, i == drain_at || $urandom_range(0, 199) == 0);
    end
    wait_idle();
  endtask

  initial begin
    int lo;
    int hi;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset band 0 to 1000
    tick(500, 1, 0, 0);
    tick(-32768, 1, 0, 0);
    tick(32767, 1, 0, 0);
    tick(0, 1, 0, 0);
    tick(1000, 1, 0, 0);
    tick(1, 1, 0, 0);
    tick(999, 1, 0, 0);
    tick(333, 1, 0, 0);
    tick(400, 1, 1, 0);
    tick(400, 1, 0, 1);
    tick(400, 0, 0, 0);
    tick(700, 1, 0, 0);
    tick(700, 0, 0, 0);
    tick(700, 1, 1, 1);
    tick(-1, 1, 0, 0);
    tick(-1, 1, 0, 1);
    wait_idle();

    // empty band
    write_band(500, 500);
    tick(500, 1, 0, 0);
    tick(499, 1, 0, 0);
    tick(501, 1, 0, 0);
    wait_idle();

    // inverted band
    write_band(300, -300);
    tick(0, 1, 0, 0);
    tick(400, 1, 0, 0);
    tick(-400, 1, 0, 0);
    wait_idle();

    // widest band
    write_band(-32768, 32767);
    tick(32767, 1, 0, 0);
    tick(-32768, 1, 0, 0);
    tick(0, 1, 0, 0);
    wait_idle();

    random_phase(-1000, 1000, 250, -1);
    random_phase(0, 1, 250, -1);
    random_phase(-32768, 32767, 250, 100);
    random_phase(32767, -32768, 250, -1);
    random_phase(-5, -5, 250, -1);
    for (int p = 0; p < 2; p++) begin
      lo = int'($signed(16'($urandom)));
      hi = int'($signed(16'($urandom)));
      if (lo > hi && $urandom_range(0, 3) != 0) begin
        random_phase(hi, lo, 250, -1);
      end else begin
        random_phase(lo, hi, 250, -1);
      end
    end

    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("cooling_valve_band_controller verification clean");
    end else begin
      $display("cooling_valve_band_controller verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("cooling_valve_band_controller verification failed");
    $finish;
  end

endmodule
